>>> src/tlbf_pkg.sv
`timescale 1ns / 1ps
// Package for the FIFO-replacement translation buffer.
// Holds field widths, the default depth, operation codes and the controller state type.
// No dependencies.
package tlbf_pkg;

	localparam int NUM_ENTRIES_DEF = 16;
	localparam int PAGE_W          = 16;
	localparam int FRAME_W         = 16;
	localparam int ENTRY_W         = PAGE_W + FRAME_W;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_ADD    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADD
	} state_t;

endpackage

>>> src/tlbf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module tlbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/fifo_replacement_tlb.sv
`timescale 1ns / 1ps
// Top level of the fully associative translation buffer with FIFO replacement.
// Depends on tlbf_pkg and tlbf_ram.
//
// Usage:
//   Command channel: drive op, page and frame with start high; the command is
//   transferred at a rising edge where start is high and busy is low. busy stays
//   high while a command is in progress.
//   Result channel: done pulses for one cycle with hit, frame_out, evicted_valid
//   and evicted_page. The receiver cannot stall; a result not taken is lost.
// Sequencing:
//   add    - read victim, then write back.
//   lookup - the entry RAM has a single read port, so the scan reads one
//            entry per cycle in index order and stops at the first valid
//            match, or after the last entry.
//   busy drops in the cycle done is shown, so a new command may be transferred
//   then; one command is in progress at a time.
// Reset (arst_n low, asynchronous): all entries invalid, insert pointer zero,
//   controller idle. Entry contents are not cleared; invalid entries are never
//   reported.
module fifo_replacement_tlb #(
	parameter int NUM_ENTRIES = tlbf_pkg::NUM_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [tlbf_pkg::PAGE_W-1:0]  page,
	input  logic [tlbf_pkg::FRAME_W-1:0] frame,
	output logic                        done,
	output logic                        hit,
	output logic [tlbf_pkg::FRAME_W-1:0] frame_out,
	output logic                        evicted_valid,
	output logic [tlbf_pkg::PAGE_W-1:0]  evicted_page
);

	localparam int IdxW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_ENTRIES - 1);

	tlbf_pkg::state_t state_q, state_d;

	logic [NUM_ENTRIES-1:0]        valid_q;
	logic [IdxW-1:0]               ptr_q;
	logic [IdxW-1:0]               idx_q, idx_d;
	logic                          op_q;
	logic [tlbf_pkg::PAGE_W-1:0]   page_q;
	logic [tlbf_pkg::FRAME_W-1:0]  frame_q;

	logic                          ram_we;
	logic [IdxW-1:0]               ram_raddr;
	logic [tlbf_pkg::ENTRY_W-1:0]  ram_rdata;
	logic [tlbf_pkg::PAGE_W-1:0]   rd_page;
	logic [tlbf_pkg::FRAME_W-1:0]  rd_frame;

	logic                          accept;
	logic                          match;
	logic                          emit;
	logic                          res_hit;
	logic [tlbf_pkg::FRAME_W-1:0]  res_frame;
	logic                          res_ev_valid;
	logic [tlbf_pkg::PAGE_W-1:0]   res_ev_page;
	logic [IdxW-1:0]               ptr_next;

	tlbf_ram #(
		.WIDTH (tlbf_pkg::ENTRY_W),
		.DEPTH (NUM_ENTRIES),
		.ADDR_W(IdxW)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q),
		.wdata({page_q, frame_q}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_page  = ram_rdata[tlbf_pkg::ENTRY_W-1 -: tlbf_pkg::PAGE_W];
	assign rd_frame = ram_rdata[tlbf_pkg::FRAME_W-1:0];
	assign busy     = (state_q != tlbf_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign match    = valid_q[idx_q] && (rd_page == page_q);
	assign ptr_next = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		ram_raddr    = idx_q;
		ram_we       = 1'b0;
		emit         = 1'b0;
		res_hit      = 1'b0;
		res_frame    = '0;
		res_ev_valid = 1'b0;
		res_ev_page  = '0;
		case (state_q)
			tlbf_pkg::ST_IDLE: begin
				if (accept) begin
					if (op == tlbf_pkg::OP_ADD) begin
						ram_raddr = ptr_q;
						state_d   = tlbf_pkg::ST_ADD;
					end else begin
						ram_raddr = '0;
						idx_d     = '0;
						state_d   = tlbf_pkg::ST_SCAN;
					end
				end
			end
			tlbf_pkg::ST_SCAN: begin
				// compare the entry read last cycle, fetch the next one
				if (match) begin
					emit      = 1'b1;
					res_hit   = 1'b1;
					res_frame = rd_frame;
					state_d   = tlbf_pkg::ST_IDLE;
				end else if (idx_q == LastIdx) begin
					emit    = 1'b1;
					state_d = tlbf_pkg::ST_IDLE;
				end else begin
					idx_d     = idx_q + 1'b1;
					ram_raddr = idx_q + 1'b1;
				end
			end
			tlbf_pkg::ST_ADD: begin
				// victim data is on the read port; overwrite it now
				ram_we       = 1'b1;
				emit         = 1'b1;
				res_ev_valid = valid_q[ptr_q];
				res_ev_page  = valid_q[ptr_q] ? rd_page : '0;
				state_d      = tlbf_pkg::ST_IDLE;
			end
			default: begin
				state_d = tlbf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlbf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= emit;
			if (ram_we) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q          <= ptr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (accept) begin
			op_q    <= op;
			page_q  <= page;
			frame_q <= frame;
		end
		if (emit) begin
			hit           <= res_hit && (op_q == tlbf_pkg::OP_LOOKUP);
			frame_out     <= res_frame;
			evicted_valid <= res_ev_valid;
			evicted_page  <= res_ev_page;
		end
	end

endmodule
